/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl that checks itself
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define A32R_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define A32R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/core/a32r_pkg.sv */
// constants, types and helper functions for the adler-32 / rotate hash
// no dependencies; imported by every module of the block
package a32r_pkg;

   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [15:0] SUM_A_SEED = 16'd1;
   localparam logic [15:0] SUM_B_SEED = 16'd0;
   localparam logic [31:0] LANE_SEED = 32'h0BAD_F00D;
   localparam logic [4:0] BYTE_TOTAL_SEED = 5'd0;

   // running adler sums
   typedef struct packed {
      logic [15:0] sum_a;
      logic [15:0] sum_b;
   } adler_sums_type;

   // value a byte bit adds to its lane
   function automatic logic [7:0] lane_addend(input logic [7:0] c, input logic [2:0] j);
      logic [7:0] sh;
      if (c[j]) begin
         sh = c << j;
      end else begin
         sh = 8'd1 << j;
      end
      return sh;
   endfunction

   // rotate left by 0 to 31
   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

endpackage

/* rtl/core/a32r_adler_step.sv */
// one byte of the adler-32 sum update, both sums reduced modulo 65521
// depends on a32r_pkg
module a32r_adler_step
   import a32r_pkg::*;
(
   input  adler_sums_type sums_cur,
   input  logic [7:0]     data_byte,
   output adler_sums_type sums_nxt
);

   logic [16:0] a_sum;
   logic [16:0] a_red;
   logic [16:0] b_sum;
   logic [16:0] b_red;

   // a plus byte, one conditional subtract
   always_comb begin
      a_sum = {1'b0, sums_cur.sum_a} + {9'd0, data_byte};
      a_red = (a_sum >= ADLER_MOD) ? (a_sum - ADLER_MOD) : a_sum;
   end

   // b plus new a, one conditional subtract
   always_comb begin
      b_sum = {1'b0, sums_cur.sum_b} + a_red;
      b_red = (b_sum >= ADLER_MOD) ? (b_sum - ADLER_MOD) : b_sum;
   end

   assign sums_nxt.sum_a = a_red[15:0];
   assign sums_nxt.sum_b = b_red[15:0];

endmodule

/* rtl/core/a32r_lane_step.sv */
// one byte of the byte-lane word update followed by a rotate left by one
// depends on a32r_pkg
module a32r_lane_step
   import a32r_pkg::*;
(
   input  logic [31:0] lane_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] lane_nxt
);

   logic [31:0] lane_add;

   // each lane takes bits l and l+4 of the byte, wrapping on its own
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_add[8*l +: 8] = lane_cur[8*l +: 8]
                            + lane_addend(data_byte, 3'(l))
                            + lane_addend(data_byte, 3'(l + 4));
      end
   end

   assign lane_nxt = {lane_add[30:0], lane_add[31]};

endmodule

/* rtl/core/adler32_rotate_hash64.sv */
// top level of the 64-bit adler-32 / rotating lane hash
// depends on a32r_pkg, a32r_adler_step, a32r_lane_step and assert_macros.svh
//
// Takes one message byte per clock and, after the byte flagged by req_last_byte, presents
// one 64-bit hash: rsp_adler_half is standard Adler-32 (b high, a low) and rsp_rotate_half
// is the lane word rotated by the byte sum mod 32. A byte is registered on transfer and
// folded into the running state as it leaves that register; for a final byte the hash is
// loaded into the result register at the same edge, which raises rsp_valid. Sustained
// rate is one byte per cycle; the input stage stalls only while a final byte waits
// behind an untaken result. State returns to its seed after each message, so messages
// may follow back to back.
`include "assert_macros.svh"

module adler32_rotate_hash64
   import a32r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_adler_half,
   output logic [31:0] rsp_rotate_half
);

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_data_ff;
   logic           s1_last_ff;
   adler_sums_type sums_ff, sums_in;
   logic [31:0]    lane_ff, lane_in;
   logic [4:0]     total_ff, total_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_adler_ff, rsp_rotate_ff;

   adler_sums_type sums_nxt;
   logic [31:0]    lane_nxt;
   logic [4:0]     total_nxt;
   logic           s1_adv;
   logic           req_take;
   logic           rsp_load;

   // per-byte update units
   a32r_adler_step u_adler (
      .sums_cur  (sums_ff),
      .data_byte (s1_data_ff),
      .sums_nxt  (sums_nxt)
   );

   a32r_lane_step u_lane (
      .lane_cur  (lane_ff),
      .data_byte (s1_data_ff),
      .lane_nxt  (lane_nxt)
   );

   assign total_nxt = total_ff + s1_data_ff[4:0];

   // handshake control
   always_comb begin
      s1_adv    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !s1_adv;
      req_take  = req_valid && !req_stall;
      rsp_load  = s1_adv && s1_last_ff;
      s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // next state: fold the byte in, or return to seed after a final byte
   always_comb begin
      sums_in  = sums_ff;
      lane_in  = lane_ff;
      total_in = total_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            sums_in.sum_a = SUM_A_SEED;
            sums_in.sum_b = SUM_B_SEED;
            lane_in       = LANE_SEED;
            total_in      = BYTE_TOTAL_SEED;
         end else begin
            sums_in  = sums_nxt;
            lane_in  = lane_nxt;
            total_in = total_nxt;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sums_ff.sum_a <= SUM_A_SEED;
         sums_ff.sum_b <= SUM_B_SEED;
         lane_ff       <= LANE_SEED;
         total_ff      <= BYTE_TOTAL_SEED;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
         lane_ff      <= lane_in;
         total_ff     <= total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (rsp_load) begin
         rsp_adler_ff  <= {sums_nxt.sum_b, sums_nxt.sum_a};
         rsp_rotate_ff <= rotl32(lane_nxt, total_nxt);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_adler_half  = rsp_adler_ff;
   assign rsp_rotate_half = rsp_rotate_ff;

   // checks
   `A32R_ASSERT_SAME(a_sums_reduced, clock, reset, 1'b1,
      ({1'b0, sums_ff.sum_a} < ADLER_MOD) && ({1'b0, sums_ff.sum_b} < ADLER_MOD))
   `A32R_ASSERT_NEXT(a_seed_after_last, clock, reset, rsp_load,
      (lane_ff == LANE_SEED) && (sums_ff.sum_a == SUM_A_SEED) && (total_ff == BYTE_TOTAL_SEED))
   `A32R_ASSERT_SAME(a_stall_only_full, clock, reset, req_stall, s1_valid_ff && s1_last_ff)
   `A32R_ASSERT_SAME(a_no_overwrite, clock, reset,
      rsp_valid_ff && rsp_stall && s1_valid_ff && s1_last_ff, req_stall && !rsp_load)

endmodule

/* bench/testbench.sv */
// self-checking bench for adler32_rotate_hash64: directed table, then random messages
// holds its own hash predictor; depends only on the rtl of the block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ADLER_BASE = 65521;
   localparam logic [31:0] LANE_START = 32'h0BAD_F00D;
   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_ITEMS = 950;
   localparam int HOLD_CYCLES = 400;
   localparam int PRESSURE_MSGS = 40;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_HIGH} fill_kind_type;

   typedef struct packed {
      logic [31:0] adler;
      logic [31:0] rotate;
   } hash_pair_type;

   // one directed transfer, with an optional hand-worked hash
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [31:0] adler;
      logic [31:0] rotate;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_adler_half;
   logic [31:0] rsp_rotate_half;

   // side-band that travels with the payload of a directed transfer
   logic          drv_typed;
   hash_pair_type drv_hash;

   // predictor state
   logic [15:0] run_a;
   logic [15:0] run_b;
   logic [31:0] run_lanes;
   logic [4:0]  run_total;

   hash_pair_type pending_hashes[$];
   stim_row_type  directed_rows [DIRECTED_ROWS];
   int          error_count = 0;
   int          hashes_checked = 0;
   int          bytes_taken = 0;
   int          cur_len = 0;
   int          longest_msg = 0;
   int          items_offered = 0;
   int          burst_left = 0;
   bit          hold_off_req = 1'b0;

   adler32_rotate_hash64 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_adler_half  (rsp_adler_half),
      .rsp_rotate_half (rsp_rotate_half)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // rotate left, amount zero is identity
   function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
      if (n == 5'd0) return x;
      return (x << n) | (x >> (32 - int'(n)));
   endfunction

   function void seed_hash();
      run_a = 16'd1;
      run_b = 16'd0;
      run_lanes = LANE_START;
      run_total = 5'd0;
   endfunction

   // fold one byte into the running state; returns 1 with the hash on a final byte
   function automatic bit absorb_byte(input logic [7:0] c, input logic last,
                                      output hash_pair_type hash);
      logic [16:0] sum;
      logic [7:0]  addend;
      int          j;
      sum = {1'b0, run_a} + 17'(c);
      if (sum >= 17'(ADLER_BASE)) sum = sum - 17'(ADLER_BASE);
      run_a = sum[15:0];
      sum = {1'b0, run_b} + {1'b0, run_a};
      if (sum >= 17'(ADLER_BASE)) sum = sum - 17'(ADLER_BASE);
      run_b = sum[15:0];
      // each bit adds to lane j mod 4, lanes wrap on their own
      for (j = 0; j < 8; j++) begin
         if (c[j]) begin
            addend = c << j;
         end else begin
            addend = 8'd1 << j;
         end
         run_lanes[8*(j%4) +: 8] = run_lanes[8*(j%4) +: 8] + addend;
      end
      run_lanes = rot_left(run_lanes, 5'd1);
      run_total = run_total + c[4:0];
      hash = '0;
      if (!last) return 1'b0;
      hash.adler = {run_b, run_a};
      hash.rotate = rot_left(run_lanes, run_total);
      seed_hash();
      return 1'b1;
   endfunction

   // both channels watched at the clock edge
   always @(posedge clock) begin : watch
      hash_pair_type want;
      hash_pair_type pred;
      if (!reset) begin
         // result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (pending_hashes.size() == 0) begin
               $display("%0t: hash with none expected, adler %h rotate %h",
                        $time, rsp_adler_half, rsp_rotate_half);
               error_count++;
            end else begin
               want = pending_hashes.pop_front();
               hashes_checked++;
               if (rsp_adler_half !== want.adler) begin
                  $display("%0t: adler_half expected %h got %h",
                           $time, want.adler, rsp_adler_half);
                  error_count++;
               end
               if (rsp_rotate_half !== want.rotate) begin
                  $display("%0t: rotate_half expected %h got %h",
                           $time, want.rotate, rsp_rotate_half);
                  error_count++;
               end
            end
         end
         // byte transfer into the predictor
         if (req_valid && !req_stall) begin
            bytes_taken++;
            cur_len++;
            if (absorb_byte(req_data_byte, req_last_byte, pred)) begin
               pending_hashes.push_back(drv_typed ? drv_hash : pred);
               if (cur_len > longest_msg) longest_msg = cur_len;
               cur_len = 0;
            end
         end
      end
   end

   // present one byte and hold it until the transfer
   task automatic offer(input logic [7:0] data, input logic last, input logic typed,
                        input hash_pair_type hash);
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      drv_typed <= typed;
      drv_hash <= hash;
      items_offered++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // bursts of random length with idle gaps between them
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   // sender idles until every expected hash has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_hashes.size() != 0);
   endtask

   task automatic send_message(input int len, input fill_kind_type kind);
      logic [7:0] b;
      int         i;
      for (i = 0; i < len; i++) begin
         case (kind)
            FILL_EXTREME: begin
               b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            FILL_HIGH: begin
               b = 8'($urandom_range(240, 255));
            end
            default: begin
               b = 8'($urandom_range(0, 255));
            end
         endcase
         pace();
         offer(b, i == len - 1, 1'b0, '0);
      end
   endtask

   // result side: stall segments of varying density, plus one long hold-off
   initial begin : receiver
      int seg_left;
      int stall_pct;
      seg_left = 0;
      stall_pct = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 150);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         seg_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int        msg;
      int        left;
      int        k;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      drv_typed <= 1'b0;
      drv_hash <= '0;
      seed_hash();
      // hashes for lone 0x00 and 0xFF worked by hand from the seed word
      directed_rows = '{
         '{8'h00, 1'b1, 1'b1, 32'h0001_0001, 32'h27E2_243D},
         '{8'hFF, 1'b1, 1'b1, 32'h0100_0100, 32'h8369_CEFC},
         '{8'h01, 1'b1, 1'b0, 32'h0, 32'h0},
         '{8'h80, 1'b1, 1'b0, 32'h0, 32'h0},
         // byte sum of 32 gives a zero final rotation
         '{8'h20, 1'b1, 1'b0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'hFF, 1'b1, 1'b0, 32'h0, 32'h0},
         '{8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'h00, 1'b1, 1'b0, 32'h0, 32'h0},
         '{8'h55, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'hAA, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'h0F, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'hF0, 1'b1, 1'b0, 32'h0, 32'h0},
         '{8'h10, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'h10, 1'b1, 1'b0, 32'h0, 32'h0},
         '{8'h7F, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'hFE, 1'b0, 1'b0, 32'h0, 32'h0},
         '{8'h01, 1'b1, 1'b0, 32'h0, 32'h0}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         pace();
         offer(row.data, row.last, row.typed, {row.adler, row.rotate});
      end

      // random messages; the first is long enough to wrap sum a
      msg = 0;
      while (items_offered < DIRECTED_ROWS + RANDOM_ITEMS) begin
         left = DIRECTED_ROWS + RANDOM_ITEMS - items_offered;
         if (msg == 0 || (left > 400 && $urandom_range(0, 39) == 0)) begin
            send_message($urandom_range(280, 300), FILL_HIGH);
         end else if ($urandom_range(0, 9) == 0) begin
            send_message($urandom_range(1, 8), FILL_EXTREME);
         end else if ($urandom_range(0, 5) == 0) begin
            send_message($urandom_range(13, 64), FILL_RANDOM);
         end else begin
            send_message($urandom_range(1, 12), FILL_RANDOM);
         end
         // back-to-back single-byte messages against a held-off receiver
         if (msg == 30) begin
            hold_off_req = 1'b1;
            for (k = 0; k < PRESSURE_MSGS; k++) begin
               offer(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            end
            wait_idle();
         end
         if (msg == 60) wait_idle();
         msg++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_hashes.size() != 0) error_count++;
      $display("run covered %0d bytes over %0d hashed messages, longest %0d bytes",
               bytes_taken, hashes_checked, longest_msg);
      $display("with sender bursts, receiver stalls and a %0d-cycle result hold-off",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d hashes outstanding", $time, pending_hashes.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* adler32_rotate_hash64.f */
+incdir+rtl/core
rtl/core/a32r_pkg.sv
rtl/core/a32r_adler_step.sv
rtl/core/a32r_lane_step.sv
rtl/core/adler32_rotate_hash64.sv
bench/testbench.sv
